// File: sv/ocas_pkg.sv
// Shared types and constants of the overlap-checked associative store.
`default_nettype none

package ocas_pkg;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  localparam int unsigned SPACE_W = 4;
  localparam int unsigned OFFS_W  = 32;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned STAT_W  = 2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_UNINIT  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_OVERLAP = 2'd3;

  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic [SPACE_W-1:0] space;
    logic [OFFS_W-1:0]  offset;
    logic [SIZE_W-1:0]  size;
  } key_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RDVAL,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: sv/ocas_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ocas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/overlap_checked_assoc_store_core.sv
// Top level of the overlap-checked associative store.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per access:
//   mode_i (0 read, 1 write), the key (addr_space_i, byte_offset_i,
//   byte_count_i) and write_value_i. Output channel (out_valid_o /
//   out_stall_i) returns exactly one transaction per access: read_value_o and
//   status_o (ok, out of storage, read uninitialized, partial overlap).
//   One access is in flight at a time. It scans every used slot of the key
//   memory, one slot a cycle through the key RAM read port, then decides and
//   writes back; a read hit then reads the value RAM in ST_RDVAL. Reset
//   clears the slot count and the control state only; slot contents are
//   never read before they are written, so no clearing pass is needed. A new
//   access is taken in the cycle after the previous one has handed its result
//   to the output register; a stalled result holds its payload, and a
//   finished access waits before loading it until the register is free.
`default_nettype none

module overlap_checked_assoc_store_core
  import ocas_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [SPACE_W-1:0] addr_space_i,
  input  wire logic [OFFS_W-1:0]  byte_offset_i,
  input  wire logic [SIZE_W-1:0]  byte_count_i,
  input  wire logic [VALUE_W-1:0] write_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [VALUE_W-1:0] read_value_o,
  output logic      [STAT_W-1:0]  status_o
);

  // Control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic             ovl_q, ovl_d;
  logic             out_vld_q, out_vld_d;

  // Payload of the access in flight and its result
  logic               mode_q, mode_d;
  key_t               key_q, key_d;
  logic [VALUE_W-1:0] wval_q, wval_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [VALUE_W-1:0] pend_val_q, pend_val_d;
  logic [STAT_W-1:0]  pend_st_q, pend_st_d;
  logic [VALUE_W-1:0] out_val_q, out_val_d;
  logic [STAT_W-1:0]  out_st_q, out_st_d;

  // Memory ports
  logic               key_we;
  logic [IDX_W-1:0]   key_waddr;
  key_t               key_rdata;
  logic               val_we;
  logic [IDX_W-1:0]   val_waddr;
  logic [VALUE_W-1:0] val_rdata;

  // Compare of the slot that the key RAM returns this cycle
  logic [OFFS_W:0] a_end, b_end;
  logic            slot_ovl, slot_eq;

  ocas_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (key_rdata)
  );

  ocas_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOTS)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (wval_q),
    .raddr_i (hit_idx_q),
    .rdata_o (val_rdata)
  );

  // Ranges end one past their last byte, with a carry bit so they never wrap.
  assign a_end = {1'b0, key_q.offset} + {{(OFFS_W + 1 - SIZE_W){1'b0}}, key_q.size};
  assign b_end = {1'b0, key_rdata.offset} + {{(OFFS_W + 1 - SIZE_W){1'b0}}, key_rdata.size};
  assign slot_ovl = (key_rdata.space == key_q.space) &&
                    ({1'b0, key_q.offset} < b_end) && ({1'b0, key_rdata.offset} < a_end);
  assign slot_eq  = (key_rdata.offset == key_q.offset) && (key_rdata.size == key_q.size);

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_vld_q;
  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      ovl_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      ovl_q     <= ovl_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    key_q      <= key_d;
    wval_q     <= wval_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    pend_val_q <= pend_val_d;
    pend_st_q  <= pend_st_d;
    out_val_q  <= out_val_d;
    out_st_q   <= out_st_d;
  end

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    scan_d     = scan_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    ovl_d      = ovl_q;
    hit_idx_d  = hit_idx_q;
    mode_d     = mode_q;
    key_d      = key_q;
    wval_d     = wval_q;
    pend_val_d = pend_val_q;
    pend_st_d  = pend_st_q;
    out_vld_d  = out_vld_q;
    out_val_d  = out_val_q;
    out_st_d   = out_st_q;
    key_we     = 1'b0;
    key_waddr  = used_q[IDX_W-1:0];
    val_we     = 1'b0;
    val_waddr  = hit_idx_q;

    // Drop the result once the receiver has taken it.
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d       = mode_i;
          key_d.space  = addr_space_i;
          key_d.offset = byte_offset_i;
          key_d.size   = byte_count_i;
          wval_d       = write_value_i;
          scan_d       = '0;
          hit_d        = 1'b0;
          ovl_d        = 1'b0;
          hit_idx_d    = '0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Fold in the slot read in the previous cycle.
        if (cmp_vld_q && slot_ovl) begin
          if (slot_eq) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
          end else begin
            ovl_d = 1'b1;
          end
        end
        // Issue the next slot, or finish once the last compare is in.
        if (scan_q < used_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IDX_W-1:0];
          scan_d    = scan_q + 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        pend_val_d = '0;
        pend_st_d  = STATUS_OK;
        state_d    = ST_DONE;
        if (ovl_q) begin
          pend_st_d = STATUS_OVERLAP;
        end else if (mode_q == MODE_WRITE) begin
          if (hit_q) begin
            val_we = 1'b1;
          end else if (used_q == CNT_W'(SLOTS)) begin
            pend_st_d = STATUS_FULL;
          end else begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            val_waddr = used_q[IDX_W-1:0];
            used_d    = used_q + 1'b1;
          end
        end else if (hit_q) begin
          state_d = ST_RDVAL;
        end else begin
          pend_st_d = STATUS_UNINIT;
        end
      end

      ST_RDVAL: begin
        pend_val_d = val_rdata;
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_val_d = pend_val_q;
          out_st_d  = pend_st_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
